// ----- src/hsv2rgb_pkg.sv -----
// hsv2rgb_pkg: types, constants and sector lookup for the HSV to RGB converter.
// No dependencies; used by every other file in src.
`default_nettype none

package hsv2rgb_pkg;

  // Field widths
  localparam int HUE_W   = 9;
  localparam int PCT_W   = 7;
  localparam int COLOR_W = 8;
  localparam int SV_W    = 14;   // s*v, at most 127*127
  localparam int K_W     = 6;    // 0..60
  localparam int NUM_W   = 20;   // channel numerator over 600000
  localparam int PROD_W  = 24;   // 17 * numerator
  localparam int Y_W     = 18;   // numerator * 17 / 64
  localparam int RPROD_W = 27;   // y * reciprocal

  // Range limits and hue geometry
  localparam int HUE_MAX     = 360;
  localparam int PCT_MAX     = 100;
  localparam int SECTOR_DEG  = 60;
  localparam int HUE_WRAP    = 120;
  localparam int CHROMA_FACT = 60;    // C' = s*v*60
  localparam int M_FACT      = 6000;  // 100*v*60

  // 255/600000 = 17/40000 = (17/64)/625
  localparam int SCALE_NUM   = 17;
  localparam int SCALE_SHIFT = 6;
  localparam int DIV_D       = 625;
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP       = (1 << RECIP_SHIFT) / DIV_D;  // 419, never over

  // 60-degree hue sectors
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,  // red to yellow
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5   // magenta to red, includes 360
  } sector_t;

  // What a channel gets before scaling: m alone, x+m or c+m
  typedef enum logic [1:0] {
    SEL_M  = 2'd0,
    SEL_XM = 2'd1,
    SEL_CM = 2'd2
  } sel_t;

  typedef struct packed {
    sel_t r;
    sel_t g;
    sel_t b;
  } rgb_sel_t;

  // Result of the front stages, one numerator per channel
  typedef struct packed {
    logic             ok;
    logic [NUM_W-1:0] num_r;
    logic [NUM_W-1:0] num_g;
    logic [NUM_W-1:0] num_b;
  } front_item_t;

  // Stage load enables for the scaling pipeline
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
    logic v4;   // stage 4 holds an item
  } scl_en_t;

  function automatic rgb_sel_t sector_sel(sector_t sec);
    rgb_sel_t sel;
    case (sec)
      SEC_RY:  sel = '{r: SEL_CM, g: SEL_XM, b: SEL_M };
      SEC_YG:  sel = '{r: SEL_XM, g: SEL_CM, b: SEL_M };
      SEC_GC:  sel = '{r: SEL_M,  g: SEL_CM, b: SEL_XM};
      SEC_CB:  sel = '{r: SEL_M,  g: SEL_XM, b: SEL_CM};
      SEC_BM:  sel = '{r: SEL_XM, g: SEL_M,  b: SEL_CM};
      SEC_MR:  sel = '{r: SEL_CM, g: SEL_M,  b: SEL_XM};
      default: sel = '{r: SEL_M,  g: SEL_M,  b: SEL_M };
    endcase
    return sel;
  endfunction

endpackage

`default_nettype wire

// ----- src/hsv2rgb_if.sv -----
// hsv2rgb_in_if / hsv2rgb_out_if: valid/ready channels of the converter.
// Depends on hsv2rgb_pkg for field widths.
`default_nettype none

interface hsv2rgb_in_if;
  logic                            valid;
  logic                            ready;
  logic [hsv2rgb_pkg::HUE_W-1:0]   hue;
  logic [hsv2rgb_pkg::PCT_W-1:0]   saturation;
  logic [hsv2rgb_pkg::PCT_W-1:0]   brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_out_if;
  logic                              valid;
  logic                              ready;
  logic [hsv2rgb_pkg::COLOR_W-1:0]   red;
  logic [hsv2rgb_pkg::COLOR_W-1:0]   green;
  logic [hsv2rgb_pkg::COLOR_W-1:0]   blue;
  logic                              valid_res;

  modport source (output valid, red, green, blue, valid_res, input ready);
  modport sink   (input valid, red, green, blue, valid_res, output ready);
endinterface

`default_nettype wire

// ----- src/hsv_to_rgb_converter.sv -----
// hsv_to_rgb_converter: top level, five-stage HSV to RGB pipeline with valid/ready.
// Depends on hsv2rgb_pkg, hsv2rgb_if, hsv2rgb_front and hsv2rgb_scale.
//
//   channel   dir  payload                           item
//   hsv_in    in   hue[9] saturation[7] brightness[7] one HSV pixel
//   rgb_out   out  red[8] green[8] blue[8] valid_res  one RGB pixel
//
// One item per cycle while rgb_out.ready holds; an accepted item passes through the
// stage 1 to 5 registers in order, and rgb_out.valid rises once it is in stage 5.
// Stages: range/sector/s*v, chroma and numerators, x17, reciprocal, correction.
// Each stage carries a valid bit and loads when empty or when the stage after
// it moves, so bubbles fill while the output waits; a stall loses nothing.
// rst (synchronous) empties the pipeline; data registers are not cleared.
`default_nettype none

module hsv_to_rgb_converter (
  input  wire logic     clk,
  input  wire logic     rst,
  hsv2rgb_in_if.sink    hsv_in,
  hsv2rgb_out_if.source rgb_out
);

  hsv2rgb_pkg::front_item_t front_item;
  logic                     front_valid;
  logic                     vld3, vld4, vld5;
  logic                     ok3, ok4, ok5;
  logic                     adv3, adv4, adv5;
  hsv2rgb_pkg::scl_en_t     en;

  hsv2rgb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .hsv_in     (hsv_in),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (adv3)
  );

  // Back-pressure chain for the scaling stages
  assign adv5  = !vld5 || rgb_out.ready;
  assign adv4  = !vld4 || adv5;
  assign adv3  = !vld3 || adv4;
  assign en.s3 = adv3;
  assign en.s4 = adv4;
  assign en.s5 = adv5;
  assign en.v4 = vld4;

  // Valid bits for stages 3 to 5
  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
    end else begin
      if (adv3) vld3 <= front_valid;
      if (adv4) vld4 <= vld3;
      if (adv5) vld5 <= vld4;
    end
  end

  // In-range flag rides along with the channel data
  always_ff @(posedge clk) begin
    if (adv3) ok3 <= front_item.ok;
    if (adv4) ok4 <= ok3;
    if (adv5) ok5 <= ok4;
  end

  hsv2rgb_scale u_scale_r (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .num   (front_item.num_r),
    .color (rgb_out.red)
  );

  hsv2rgb_scale u_scale_g (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .num   (front_item.num_g),
    .color (rgb_out.green)
  );

  hsv2rgb_scale u_scale_b (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .num   (front_item.num_b),
    .color (rgb_out.blue)
  );

  assign rgb_out.valid     = vld5;
  assign rgb_out.valid_res = ok5;

  // Out-of-range items come out black
  a_oor_black: assert property (@(posedge clk) disable iff (rst)
    rgb_out.valid && !rgb_out.valid_res |->
      rgb_out.red == '0 && rgb_out.green == '0 && rgb_out.blue == '0)
    else $error("converter: out-of-range item with nonzero color");

  // Pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !vld3 && !vld4 && !vld5)
    else $error("converter: pipeline not empty after reset");

  // A held stage-3 item is not dropped while stage 4 is blocked
  a_hold_s3: assert property (@(posedge clk) disable iff (rst)
    vld3 && !adv4 |=> vld3)
    else $error("converter: stage 3 item lost during stall");

endmodule

`default_nettype wire

// ----- src/hsv2rgb_front.sv -----
// hsv2rgb_front: stages 1 and 2, range check, sector, chroma and channel numerators.
// Depends on hsv2rgb_pkg and hsv2rgb_in_if.
`default_nettype none

module hsv2rgb_front (
  input  wire logic               clk,
  input  wire logic               rst,
  hsv2rgb_in_if.sink              hsv_in,
  output hsv2rgb_pkg::front_item_t item,
  output logic                    item_valid,
  input  wire logic               item_ready
);

  // Stage 1 registers
  logic                              vld1;
  logic                              ok1;
  hsv2rgb_pkg::sector_t              sec1;
  logic [hsv2rgb_pkg::SV_W-1:0]      sv1;
  logic [hsv2rgb_pkg::K_W-1:0]       k1;
  logic [hsv2rgb_pkg::PCT_W-1:0]     v1;

  // Stage 2 registers
  logic                              vld2;
  hsv2rgb_pkg::front_item_t          item2;

  logic adv1, adv2;

  // Stage 1 combinational
  logic                              ok_c;
  hsv2rgb_pkg::sector_t              sec_c;
  logic [hsv2rgb_pkg::HUE_W-1:0]     base_c;
  logic [hsv2rgb_pkg::HUE_W-1:0]     hm_c;
  logic [hsv2rgb_pkg::HUE_W-1:0]     kfull_c;
  logic [hsv2rgb_pkg::SV_W-1:0]      sv_c;

  // Stage 2 combinational
  logic [hsv2rgb_pkg::NUM_W-1:0]     c_c, x_c, m_c, cm_c, xm_c;
  hsv2rgb_pkg::rgb_sel_t             sel_c;
  hsv2rgb_pkg::front_item_t          item_c;

  // Pipeline advance, each stage moves when it is empty or its successor moves
  assign adv2         = !vld2 || item_ready;
  assign adv1         = !vld1 || adv2;
  assign hsv_in.ready = adv1;
  assign item_valid   = vld2;
  assign item         = item2;

  // Range check and 60-degree sector
  always_comb begin
    ok_c = (hsv_in.hue <= hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::HUE_MAX))
        && (hsv_in.saturation <= hsv2rgb_pkg::PCT_W'(hsv2rgb_pkg::PCT_MAX))
        && (hsv_in.brightness <= hsv2rgb_pkg::PCT_W'(hsv2rgb_pkg::PCT_MAX));
    if (hsv_in.hue < hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::SECTOR_DEG)) begin
      sec_c = hsv2rgb_pkg::SEC_RY;
    end else if (hsv_in.hue < hsv2rgb_pkg::HUE_W'(2 * hsv2rgb_pkg::SECTOR_DEG)) begin
      sec_c = hsv2rgb_pkg::SEC_YG;
    end else if (hsv_in.hue < hsv2rgb_pkg::HUE_W'(3 * hsv2rgb_pkg::SECTOR_DEG)) begin
      sec_c = hsv2rgb_pkg::SEC_GC;
    end else if (hsv_in.hue < hsv2rgb_pkg::HUE_W'(4 * hsv2rgb_pkg::SECTOR_DEG)) begin
      sec_c = hsv2rgb_pkg::SEC_CB;
    end else if (hsv_in.hue < hsv2rgb_pkg::HUE_W'(5 * hsv2rgb_pkg::SECTOR_DEG)) begin
      sec_c = hsv2rgb_pkg::SEC_BM;
    end else begin
      sec_c = hsv2rgb_pkg::SEC_MR;
    end
  end

  // hue less the base of its 120-degree span from the sector, then k = 60 - |hm - 60|
  always_comb begin
    case (sec_c)
      hsv2rgb_pkg::SEC_RY, hsv2rgb_pkg::SEC_YG: base_c = '0;
      hsv2rgb_pkg::SEC_GC, hsv2rgb_pkg::SEC_CB:
        base_c = hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::HUE_WRAP);
      default: base_c = hsv2rgb_pkg::HUE_W'(2 * hsv2rgb_pkg::HUE_WRAP);
    endcase
    hm_c    = hsv_in.hue - base_c;
    kfull_c = (hm_c >= hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::SECTOR_DEG))
            ? hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::HUE_WRAP) - hm_c : hm_c;
    sv_c    = {{(hsv2rgb_pkg::SV_W - hsv2rgb_pkg::PCT_W){1'b0}}, hsv_in.saturation}
            * {{(hsv2rgb_pkg::SV_W - hsv2rgb_pkg::PCT_W){1'b0}}, hsv_in.brightness};
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (adv1) begin
      vld1 <= hsv_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      ok1  <= ok_c;
      sec1 <= sec_c;
      sv1  <= sv_c;
      k1   <= kfull_c[hsv2rgb_pkg::K_W-1:0];
      v1   <= hsv_in.brightness;
    end
  end

  // Chroma, x and m over 600000; pick per channel, zero when out of range
  always_comb begin
    c_c  = {{(hsv2rgb_pkg::NUM_W - hsv2rgb_pkg::SV_W){1'b0}}, sv1}
         * hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::CHROMA_FACT);
    x_c  = {{(hsv2rgb_pkg::NUM_W - hsv2rgb_pkg::SV_W){1'b0}}, sv1}
         * {{(hsv2rgb_pkg::NUM_W - hsv2rgb_pkg::K_W){1'b0}}, k1};
    m_c  = {{(hsv2rgb_pkg::NUM_W - hsv2rgb_pkg::PCT_W){1'b0}}, v1}
         * hsv2rgb_pkg::NUM_W'(hsv2rgb_pkg::M_FACT) - c_c;
    cm_c = c_c + m_c;
    xm_c = x_c + m_c;
    sel_c = hsv2rgb_pkg::sector_sel(sec1);
    item_c.ok = ok1;
    case (sel_c.r)
      hsv2rgb_pkg::SEL_CM: item_c.num_r = cm_c;
      hsv2rgb_pkg::SEL_XM: item_c.num_r = xm_c;
      default:             item_c.num_r = m_c;
    endcase
    case (sel_c.g)
      hsv2rgb_pkg::SEL_CM: item_c.num_g = cm_c;
      hsv2rgb_pkg::SEL_XM: item_c.num_g = xm_c;
      default:             item_c.num_g = m_c;
    endcase
    case (sel_c.b)
      hsv2rgb_pkg::SEL_CM: item_c.num_b = cm_c;
      hsv2rgb_pkg::SEL_XM: item_c.num_b = xm_c;
      default:             item_c.num_b = m_c;
    endcase
    if (!ok1) begin
      item_c.num_r = '0;
      item_c.num_g = '0;
      item_c.num_b = '0;
    end
  end

  // Stage 2 register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (adv2) begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      item2 <= item_c;
    end
  end

endmodule

`default_nettype wire

// ----- src/hsv2rgb_scale.sv -----
// hsv2rgb_scale: stages 3 to 5 for one channel, floor(numerator * 255 / 600000).
// Depends on hsv2rgb_pkg; the top level drives the stage enables.
`default_nettype none

module hsv2rgb_scale (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  hsv2rgb_pkg::scl_en_t               en,
  input  wire logic [hsv2rgb_pkg::NUM_W-1:0] num,
  output logic [hsv2rgb_pkg::COLOR_W-1:0]    color
);

  logic [hsv2rgb_pkg::PROD_W-1:0]  prod3_c;
  logic [hsv2rgb_pkg::Y_W-1:0]     y3;
  logic [hsv2rgb_pkg::RPROD_W-1:0] prod4_c;
  logic [hsv2rgb_pkg::Y_W-1:0]     y4;
  logic [hsv2rgb_pkg::COLOR_W-1:0] q4;
  logic [hsv2rgb_pkg::Y_W-1:0]     rem_c;
  logic [hsv2rgb_pkg::COLOR_W-1:0] q_c;

  // Stage 3: times 17, drop six bits (exact nested floor)
  assign prod3_c = {{(hsv2rgb_pkg::PROD_W - hsv2rgb_pkg::NUM_W){1'b0}}, num}
                 * hsv2rgb_pkg::PROD_W'(hsv2rgb_pkg::SCALE_NUM);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      y3 <= prod3_c[hsv2rgb_pkg::PROD_W-1:hsv2rgb_pkg::SCALE_SHIFT];
    end
  end

  // Stage 4: reciprocal estimate of y / 625, low by at most one
  assign prod4_c = {{(hsv2rgb_pkg::RPROD_W - hsv2rgb_pkg::Y_W){1'b0}}, y3}
                 * hsv2rgb_pkg::RPROD_W'(hsv2rgb_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (en.s4) begin
      y4 <= y3;
      q4 <= prod4_c[hsv2rgb_pkg::RECIP_SHIFT + hsv2rgb_pkg::COLOR_W - 1:
                    hsv2rgb_pkg::RECIP_SHIFT];
    end
  end

  // Stage 5: remainder check and correction
  always_comb begin
    rem_c = y4 - {{(hsv2rgb_pkg::Y_W - hsv2rgb_pkg::COLOR_W){1'b0}}, q4}
               * hsv2rgb_pkg::Y_W'(hsv2rgb_pkg::DIV_D);
    q_c   = (rem_c >= hsv2rgb_pkg::Y_W'(hsv2rgb_pkg::DIV_D)) ? q4 + 1'b1 : q4;
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      color <= q_c;
    end
  end

  // Estimate is never high and never low by more than one
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    en.s5 && en.v4 |-> rem_c < hsv2rgb_pkg::Y_W'(2 * hsv2rgb_pkg::DIV_D))
    else $error("scale: reciprocal estimate out of bounds");

endmodule

`default_nettype wire
